>>> design/mfr_pkg.sv
// Shared types, codes and helper functions for the meter frame receiver.
package mfr_pkg;

  localparam int DataW = 56;
  localparam int PaddrW = 4;

  localparam logic [8:0] MAX_FRAME = 9'd511;

  localparam logic [1:0] REQ_START = 2'd0;
  localparam logic [1:0] REQ_BYTE  = 2'd1;
  localparam logic [1:0] REQ_TICK  = 2'd2;

  localparam logic [1:0] REG_HUNT_TO  = 2'd0;
  localparam logic [1:0] REG_FRAME_TO = 2'd1;
  localparam logic [1:0] REG_LONG_TO  = 2'd2;
  localparam logic [1:0] REG_FIX_LEN  = 2'd3;

  localparam logic [2:0] FT_NONE    = 3'd0;
  localparam logic [2:0] FT_UNKNOWN = 3'd1;
  localparam logic [2:0] FT_LEN123  = 3'd2;
  localparam logic [2:0] FT_LEN121  = 3'd3;
  localparam logic [2:0] FT_LEN114  = 3'd4;
  localparam logic [2:0] FT_FIXED   = 3'd5;

  localparam logic [7:0] BYTE_FLAG  = 8'h7E;
  localparam logic [7:0] BYTE_FIXED = 8'hDB;
  localparam logic [7:0] BYTE_FMT   = 8'hA0;

  typedef struct packed {
    logic [15:0] hunt_timeout;
    logic [15:0] frame_timeout;
    logic [15:0] long_frame_timeout;
    logic [8:0]  fixed_frame_len;
  } cfg_t;

  typedef struct packed {
    logic       result_kind;
    logic [7:0] data_byte;
    logic [8:0] byte_index;
    logic [2:0] frame_type;
    logic [8:0] byte_count;
    logic       end_byte_ok;
    logic [4:0] cipher_start;
    logic [8:0] cipher_len;
    logic [4:0] iv_head_start;
    logic [4:0] iv_tail_start;
    logic       last;
  } res_t;

  typedef struct packed {
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
  } push_t;

  function automatic res_t make_echo(logic [7:0] b, logic [8:0] idx);
    res_t r;
    r = '0;
    r.data_byte  = b;
    r.byte_index = idx;
    return r;
  endfunction

  function automatic res_t make_summary(logic [8:0] cnt, logic fixed, logic eok);
    res_t r;
    r = '0;
    r.result_kind = 1'b1;
    r.last        = 1'b1;
    r.byte_count  = cnt;
    r.end_byte_ok = eok;
    if (cnt == 9'd0) r.frame_type = FT_NONE;
    else if (cnt > 9'd10 && fixed) r.frame_type = FT_FIXED;
    else if (cnt == 9'd123) r.frame_type = FT_LEN123;
    else if (cnt == 9'd121) r.frame_type = FT_LEN121;
    else if (cnt == 9'd114) r.frame_type = FT_LEN114;
    else r.frame_type = FT_UNKNOWN;
    case (r.frame_type)
      FT_LEN123: begin
        r.cipher_start = 5'd30; r.cipher_len = 9'd90;
        r.iv_head_start = 5'd16; r.iv_tail_start = 5'd26;
      end
      FT_LEN121: begin
        r.cipher_start = 5'd28; r.cipher_len = 9'd90;
        r.iv_head_start = 5'd14; r.iv_tail_start = 5'd24;
      end
      FT_LEN114: begin
        r.cipher_start = 5'd30; r.cipher_len = 9'd81;
        r.iv_head_start = 5'd16; r.iv_tail_start = 5'd26;
      end
      FT_FIXED: begin
        r.cipher_start = 5'd18; r.cipher_len = 9'd481;
        r.iv_head_start = 5'd2; r.iv_tail_start = 5'd14;
      end
      default: begin
        r.cipher_start = 5'd0; r.cipher_len = 9'd0;
        r.iv_head_start = 5'd0; r.iv_tail_start = 5'd0;
      end
    endcase
    return r;
  endfunction

endpackage

>>> design/mfr_cfg.sv
// APB register file holding the timeouts and the fixed frame length.
module mfr_cfg (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [mfr_pkg::PaddrW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output mfr_pkg::cfg_t              cfg
);
  import mfr_pkg::*;

  logic [1:0] idx;

  assign idx    = paddr[3:2];
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.hunt_timeout       <= 16'd2000;
      cfg.frame_timeout      <= 16'd1000;
      cfg.long_frame_timeout <= 16'd3000;
      cfg.fixed_frame_len    <= 9'd511;
    end else if (psel && penable && pwrite && pready) begin
      case (idx)
        REG_HUNT_TO:  cfg.hunt_timeout       <= pwdata[15:0];
        REG_FRAME_TO: cfg.frame_timeout      <= pwdata[15:0];
        REG_LONG_TO:  cfg.long_frame_timeout <= pwdata[15:0];
        REG_FIX_LEN:  cfg.fixed_frame_len    <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_HUNT_TO:  prdata = {16'd0, cfg.hunt_timeout};
      REG_FRAME_TO: prdata = {16'd0, cfg.frame_timeout};
      REG_LONG_TO:  prdata = {16'd0, cfg.long_frame_timeout};
      REG_FIX_LEN:  prdata = {23'd0, cfg.fixed_frame_len};
      default:      prdata = 32'd0;
    endcase
  end

endmodule

>>> design/mfr_core.sv
// Frame hunt, length tracking and timeout FSM; one item per cycle with take.
module mfr_core (
  input  logic           clk,
  input  logic           rst,
  input  logic           take,
  input  logic [1:0]     req_type,
  input  logic [7:0]     rx_byte,
  input  mfr_pkg::cfg_t  cfg,
  output mfr_pkg::push_t push
);
  import mfr_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE, PH_HUNT, PH_SEEK, PH_LEN, PH_DATA, PH_FIXED
  } phase_t;

  phase_t      phase, phase_next;
  logic [15:0] elapsed_ms, elapsed_ms_next;
  logic [8:0]  frame_count, frame_count_next;
  logic [8:0]  target_len, target_len_next;
  logic        fixed_mode, fixed_mode_next;
  logic        end_ok, end_ok_next;
  logic        do_echo, do_sum;
  logic [8:0]  echo_idx;
  logic [15:0] limit;
  res_t        echo_res, sum_res;

  always_comb begin
    phase_next       = phase;
    elapsed_ms_next  = elapsed_ms;
    frame_count_next = frame_count;
    target_len_next  = target_len;
    fixed_mode_next  = fixed_mode;
    end_ok_next      = end_ok;
    do_echo          = 1'b0;
    do_sum           = 1'b0;
    echo_idx         = 9'd0;
    limit            = cfg.frame_timeout;
    case (phase)
      PH_HUNT:  limit = cfg.hunt_timeout;
      PH_FIXED: limit = cfg.long_frame_timeout;
      default:  limit = cfg.frame_timeout;
    endcase

    case (req_type)
      REQ_START: begin
        phase_next       = PH_HUNT;
        elapsed_ms_next  = 16'd0;
        frame_count_next = 9'd0;
        target_len_next  = 9'd0;
        fixed_mode_next  = 1'b0;
        end_ok_next      = 1'b0;
        do_sum           = (cfg.hunt_timeout == 16'd0);
      end
      REQ_TICK: begin
        if (phase != PH_IDLE) begin
          if (elapsed_ms != 16'hFFFF) elapsed_ms_next = elapsed_ms + 16'd1;
          do_sum = (elapsed_ms_next >= limit);
        end
      end
      REQ_BYTE: begin
        case (phase)
          PH_HUNT: begin
            if (rx_byte == BYTE_FLAG) begin
              do_echo         = 1'b1;
              phase_next      = PH_SEEK;
              elapsed_ms_next = 16'd0;
              do_sum          = (cfg.frame_timeout == 16'd0);
            end else if (rx_byte == BYTE_FIXED) begin
              do_echo          = 1'b1;
              fixed_mode_next  = 1'b1;
              frame_count_next = 9'd1;
              target_len_next  = (cfg.fixed_frame_len > MAX_FRAME) ? MAX_FRAME
                                                                   : cfg.fixed_frame_len;
              if (target_len_next <= 9'd1) begin
                do_sum = 1'b1;
              end else begin
                phase_next      = PH_FIXED;
                elapsed_ms_next = 16'd0;
                do_sum          = (cfg.long_frame_timeout == 16'd0);
              end
            end
          end
          PH_SEEK: begin
            if (rx_byte == BYTE_FMT) begin
              do_echo    = 1'b1;
              echo_idx   = 9'd1;
              phase_next = PH_LEN;
            end
          end
          PH_LEN: begin
            do_echo          = 1'b1;
            echo_idx         = 9'd2;
            frame_count_next = 9'd3;
            // a length below two is echoed only; the next byte is the length
            if (rx_byte >= 8'd2) begin
              target_len_next = {1'b0, rx_byte} + 9'd2;
              phase_next      = PH_DATA;
            end
          end
          PH_DATA: begin
            do_echo          = 1'b1;
            echo_idx         = frame_count;
            frame_count_next = frame_count + 9'd1;
            if (frame_count_next >= target_len) begin
              end_ok_next = (rx_byte == BYTE_FLAG);
              do_sum      = 1'b1;
            end
          end
          PH_FIXED: begin
            do_echo          = 1'b1;
            echo_idx         = frame_count;
            frame_count_next = frame_count + 9'd1;
            do_sum           = (frame_count_next >= target_len);
          end
          default: ;
        endcase
      end
      default: ;
    endcase

    if (do_sum) phase_next = PH_IDLE;

    echo_res = make_echo(rx_byte, echo_idx);
    sum_res  = make_summary(frame_count_next, fixed_mode_next, end_ok_next);

    push.cnt = take ? ({1'b0, do_echo} + {1'b0, do_sum}) : 2'd0;
    push.r0  = do_echo ? echo_res : sum_res;
    push.r1  = sum_res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      elapsed_ms  <= 16'd0;
      frame_count <= 9'd0;
      target_len  <= 9'd0;
      fixed_mode  <= 1'b0;
      end_ok      <= 1'b0;
    end else if (take) begin
      phase       <= phase_next;
      elapsed_ms  <= elapsed_ms_next;
      frame_count <= frame_count_next;
      target_len  <= target_len_next;
      fixed_mode  <= fixed_mode_next;
      end_ok      <= end_ok_next;
    end
  end

endmodule

>>> design/mfr_outq.sv
// Four-entry result queue: up to two pushes and one pop per cycle.
module mfr_outq (
  input  logic           clk,
  input  logic           rst,
  input  mfr_pkg::push_t push,
  output logic           room2,
  output logic           out_valid,
  input  logic           out_ready,
  output mfr_pkg::res_t  out_res
);
  import mfr_pkg::*;

  res_t       mem [4];
  logic [1:0] wr_ptr, rd_ptr;
  logic [2:0] count;
  logic       pop;

  assign out_valid = (count != 3'd0);
  assign pop       = out_valid && out_ready;
  assign room2     = (count <= 3'd2);
  assign out_res   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) mem[wr_ptr] <= push.r0;
    if (push.cnt == 2'd2) mem[wr_ptr + 2'd1] <= push.r1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 2'd0;
      rd_ptr <= 2'd0;
      count  <= 3'd0;
    end else begin
      wr_ptr <= wr_ptr + push.cnt;
      if (pop) rd_ptr <= rd_ptr + 2'd1;
      count <= count + {1'b0, push.cnt} - {2'd0, pop};
    end
  end

endmodule

>>> design/meter_frame_receiver.sv
// Top level of the meter frame receiver: stream in, stream out, APB registers.
//
//  channel   | dir | transfer when             | payload
//  ----------+-----+---------------------------+---------------------------------
//  s_*       | in  | s_tvalid & s_tready       | tuser req_type, tdata rx_byte
//  m_*       | out | m_tvalid & m_tready       | tuser result_kind, tdata, tlast
//  APB       | in  | psel&penable&pwrite&pready| regs at 0x0,0x4,0x8,0xC
//
// An input transfer is decoded in the cycle it is taken; the state update and
// its zero, one or two results land at the next edge, so a result is offered
// in the cycle after its transfer at the earliest. s_tready is high while the
// four-entry result queue has two free slots: one item per cycle while the sink
// keeps up, an echo plus summary gives the sink two results to take, and m_tready low
// fills the queue until input stalls. rst (sync) empties queue, idles, loads defaults.
module meter_frame_receiver (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [7:0]                 s_tdata,  // [7:0] rx_byte
  input  logic [1:0]                 s_tuser,  // [1:0] req_type
  output logic                       m_tvalid,
  input  logic                       m_tready,
  // [7:0] data_byte, [16:8] byte_index, [19:17] frame_type,
  // [28:20] byte_count, [29] end_byte_ok, [34:30] cipher_start,
  // [43:35] cipher_len, [48:44] iv_head_start, [53:49] iv_tail_start, rest 0
  output logic [mfr_pkg::DataW-1:0]  m_tdata,
  output logic                       m_tuser,  // [0] result_kind
  output logic                       m_tlast,  // last
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [mfr_pkg::PaddrW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import mfr_pkg::*;

  cfg_t  cfg;
  push_t push;
  res_t  res;
  logic  take;

  assign take = s_tvalid && s_tready;

  mfr_cfg u_cfg (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  mfr_core u_core (
    .clk, .rst, .take, .req_type(s_tuser), .rx_byte(s_tdata), .cfg, .push
  );

  mfr_outq u_outq (
    .clk, .rst, .push, .room2(s_tready),
    .out_valid(m_tvalid), .out_ready(m_tready), .out_res(res)
  );

  assign m_tdata = {2'b00, res.iv_tail_start, res.iv_head_start, res.cipher_len,
                    res.cipher_start, res.end_byte_ok, res.byte_count,
                    res.frame_type, res.byte_index, res.data_byte};
  assign m_tuser = res.result_kind;
  assign m_tlast = res.last;

endmodule

>>> bench/frame_checker.sv
`timescale 1ns / 100ps
// Checker for the meter frame receiver: tracks its state and compares results.
module frame_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  input  logic                       s_tready,
  input  logic [7:0]                 s_tdata,
  input  logic [1:0]                 s_tuser,
  input  logic                       m_tvalid,
  input  logic                       m_tready,
  input  logic [mfr_pkg::DataW-1:0]  m_tdata,
  input  logic                       m_tuser,
  input  logic                       m_tlast,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [mfr_pkg::PaddrW-1:0] paddr,
  input  logic [31:0]                pwdata,
  input  logic [31:0]                prdata,
  input  logic                       pready,
  input  logic                       run_done,
  output int                         pending,
  output int                         mismatches
);
  import mfr_pkg::*;

  typedef enum logic [2:0] {
    RX_IDLE, RX_HUNT, RX_SEEK, RX_LEN, RX_DATA, RX_FIXED
  } rx_phase_t;

  // register copies
  logic [15:0] hunt_limit, frame_limit, long_limit;
  logic [8:0]  fixed_len;

  // receiver state
  rx_phase_t   rx_phase;
  logic [15:0] elapsed;
  logic [8:0]  count;
  logic [8:0]  target;
  logic        fixed_mode;
  logic        flag_ok;

  res_t due_results[$];
  int   results_checked;
  int   types_seen[8];
  logic tail_checked;

  task automatic flag_mismatch(input string what);
    $display("%0t checker: %s", $time, what);
    mismatches++;
  endtask

  task automatic expect_echo(input logic [7:0] b, input logic [8:0] idx);
    res_t r;
    r = '0;
    r.data_byte  = b;
    r.byte_index = idx;
    due_results.push_back(r);
  endtask

  // frame type comes from the count and the fixed mode; offsets from the type
  task automatic close_frame();
    res_t r;
    r = '0;
    r.result_kind = 1'b1;
    r.last        = 1'b1;
    r.byte_count  = count;
    r.end_byte_ok = flag_ok;
    if (count == 9'd0)                 r.frame_type = FT_NONE;
    else if (count > 9'd10 && fixed_mode) r.frame_type = FT_FIXED;
    else if (count == 9'd123)          r.frame_type = FT_LEN123;
    else if (count == 9'd121)          r.frame_type = FT_LEN121;
    else if (count == 9'd114)          r.frame_type = FT_LEN114;
    else                               r.frame_type = FT_UNKNOWN;
    case (r.frame_type)
      FT_LEN123: {r.cipher_start, r.cipher_len, r.iv_head_start, r.iv_tail_start} =
                   {5'd30, 9'd90, 5'd16, 5'd26};
      FT_LEN121: {r.cipher_start, r.cipher_len, r.iv_head_start, r.iv_tail_start} =
                   {5'd28, 9'd90, 5'd14, 5'd24};
      FT_LEN114: {r.cipher_start, r.cipher_len, r.iv_head_start, r.iv_tail_start} =
                   {5'd30, 9'd81, 5'd16, 5'd26};
      FT_FIXED:  {r.cipher_start, r.cipher_len, r.iv_head_start, r.iv_tail_start} =
                   {5'd18, 9'd481, 5'd2, 5'd14};
      default: ;
    endcase
    rx_phase = RX_IDLE;
    due_results.push_back(r);
  endtask

  task automatic check_deadline();
    logic [15:0] limit;
    if (rx_phase == RX_IDLE) return;
    if (rx_phase == RX_HUNT)       limit = hunt_limit;
    else if (rx_phase == RX_FIXED) limit = long_limit;
    else                           limit = frame_limit;
    if (elapsed >= limit) close_frame();
  endtask

  task automatic track_request(input logic [1:0] req, input logic [7:0] b);
    case (req)
      REQ_START: begin
        rx_phase   = RX_HUNT;
        elapsed    = '0;
        count      = '0;
        target     = '0;
        fixed_mode = 1'b0;
        flag_ok    = 1'b0;
        check_deadline();
      end
      REQ_TICK: begin
        if (rx_phase != RX_IDLE) begin
          if (elapsed != 16'hFFFF) elapsed++;
          check_deadline();
        end
      end
      REQ_BYTE: begin
        case (rx_phase)
          RX_HUNT: begin
            if (b == BYTE_FLAG) begin
              expect_echo(b, 9'd0);
              rx_phase = RX_SEEK;
              elapsed  = '0;
              check_deadline();
            end else if (b == BYTE_FIXED) begin
              fixed_mode = 1'b1;
              count      = 9'd1;
              target     = (fixed_len > MAX_FRAME) ? MAX_FRAME : fixed_len;
              expect_echo(b, 9'd0);
              if (count >= target) begin
                close_frame();
              end else begin
                rx_phase = RX_FIXED;
                elapsed  = '0;
                check_deadline();
              end
            end
          end
          RX_SEEK: begin
            if (b == BYTE_FMT) begin
              expect_echo(b, 9'd1);
              rx_phase = RX_LEN;
            end
          end
          RX_LEN: begin
            expect_echo(b, 9'd2);
            count = 9'd3;
            // a length below two is echoed only; the next byte is the length
            if (b >= 8'd2) begin
              target   = {1'b0, b} + 9'd2;
              rx_phase = RX_DATA;
            end
          end
          RX_DATA: begin
            expect_echo(b, count);
            count++;
            if (count >= target) begin
              flag_ok = (b == BYTE_FLAG);
              close_frame();
            end
          end
          RX_FIXED: begin
            expect_echo(b, count);
            count++;
            if (count >= target) close_frame();
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  endtask

  task automatic check_field(input string name, input int unsigned got,
                             input int unsigned want);
    if (got != want)
      flag_mismatch($sformatf("result %0d %s: got %0d, expected %0d",
                              results_checked, name, got, want));
  endtask

  always @(posedge clk) begin : watch
    res_t want;
    logic [31:0] reg_value;
    if (rst) begin
      due_results.delete();
      hunt_limit   = 16'd2000;
      frame_limit  = 16'd1000;
      long_limit   = 16'd3000;
      fixed_len    = 9'd511;
      rx_phase     = RX_IDLE;
      elapsed      = '0;
      count        = '0;
      target       = '0;
      fixed_mode   = 1'b0;
      flag_ok      = 1'b0;
      tail_checked = 1'b0;
    end else begin
      // results first: nothing taken at this edge can have left yet
      if (m_tvalid && m_tready) begin
        if (due_results.size() == 0) begin
          flag_mismatch($sformatf("unexpected result, tdata %h", m_tdata));
        end else begin
          want = due_results.pop_front();
          check_field("result_kind", 32'(m_tuser), 32'(want.result_kind));
          check_field("data_byte", 32'(m_tdata[7:0]), 32'(want.data_byte));
          check_field("byte_index", 32'(m_tdata[16:8]), 32'(want.byte_index));
          check_field("frame_type", 32'(m_tdata[19:17]), 32'(want.frame_type));
          check_field("byte_count", 32'(m_tdata[28:20]), 32'(want.byte_count));
          check_field("end_byte_ok", 32'(m_tdata[29]), 32'(want.end_byte_ok));
          check_field("cipher_start", 32'(m_tdata[34:30]), 32'(want.cipher_start));
          check_field("cipher_len", 32'(m_tdata[43:35]), 32'(want.cipher_len));
          check_field("iv_head_start", 32'(m_tdata[48:44]), 32'(want.iv_head_start));
          check_field("iv_tail_start", 32'(m_tdata[53:49]), 32'(want.iv_tail_start));
          check_field("tdata pad", 32'(m_tdata[DataW-1:54]), 32'd0);
          check_field("last", 32'(m_tlast), 32'(want.last));
          if (want.result_kind) types_seen[want.frame_type]++;
        end
        results_checked++;
      end
      if (s_tvalid && s_tready) track_request(s_tuser, s_tdata);
      if (psel && penable && pready) begin
        if (pwrite) begin
          case (paddr[3:2])
            REG_HUNT_TO:  hunt_limit  = pwdata[15:0];
            REG_FRAME_TO: frame_limit = pwdata[15:0];
            REG_LONG_TO:  long_limit  = pwdata[15:0];
            REG_FIX_LEN:  fixed_len   = pwdata[8:0];
            default: ;
          endcase
        end else begin
          case (paddr[3:2])
            REG_HUNT_TO:  reg_value = {16'd0, hunt_limit};
            REG_FRAME_TO: reg_value = {16'd0, frame_limit};
            REG_LONG_TO:  reg_value = {16'd0, long_limit};
            default:      reg_value = {23'd0, fixed_len};
          endcase
          if (prdata != reg_value)
            flag_mismatch($sformatf("register at %h reads %h, expected %h",
                                    paddr, prdata, reg_value));
        end
      end
      if (run_done && !tail_checked) begin
        tail_checked = 1'b1;
        if (due_results.size() != 0)
          flag_mismatch($sformatf("%0d expected results never arrived",
                                  due_results.size()));
        $display("checker: %0d results compared; summaries by type none %0d, unknown %0d,",
                 results_checked, types_seen[FT_NONE], types_seen[FT_UNKNOWN]);
        $display("checker: len123 %0d, len121 %0d, len114 %0d, fixed %0d",
                 types_seen[FT_LEN123], types_seen[FT_LEN121], types_seen[FT_LEN114],
                 types_seen[FT_FIXED]);
      end
    end
    pending <= due_results.size();
  end

endmodule

>>> bench/testbench.sv
`timescale 1ns / 100ps
// Top of the meter frame receiver bench: clock, reset, stimulus, flow control and verdict.
module testbench;
  import mfr_pkg::*;

  // request code the block must ignore
  localparam logic [1:0] REQ_RESERVED = 2'd3;
  // input transfers per register setting in the random part
  localparam int PhaseItems = 55;
  // length of a forced sink hold-off, in cycles
  localparam int HoldCycles = 400;

  logic                clk = 1'b0;
  logic                rst = 1'b1;

  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [7:0]          s_tdata = '0;
  logic [1:0]          s_tuser = REQ_START;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [DataW-1:0]    m_tdata;
  logic                m_tuser;
  logic                m_tlast;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [PaddrW-1:0]   paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;

  logic                run_done = 1'b0;
  int                  pending;
  int                  mismatches;

  // flow control knobs (percent of cycles)
  int                  src_idle = 0;
  int                  sink_stall = 0;
  // forced hold-offs: requested by the stimulus, counted out by the sink
  int                  hold_requests = 0;
  int                  holds_done = 0;
  int                  hold_left = 0;

  int                  items_sent = 0;
  // current register values, needed to shape frames and timeouts
  logic [15:0]         cur_hunt = 16'd2000;
  logic [8:0]          cur_fix_len = 9'd511;

  meter_frame_receiver i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  frame_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .run_done   (run_done),
    .pending    (pending),
    .mismatches (mismatches)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Sink side. A requested hold-off keeps tready low until hold_left runs out
  // while the source keeps offering, so the result queue fills and s_tready drops.
  always @(posedge clk) begin : sink
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else if (holds_done < hold_requests) begin
      holds_done <= holds_done + 1;
      hold_left  <= HoldCycles;
      m_tready   <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= sink_stall);
    end
  end

  // hard stop in case the block hangs
  initial begin : watchdog
    #5ms;
    $display("testbench: FAIL");
    $finish;
  end

  // One input transfer. Gaps come before the item; tvalid stays high into the
  // next call so back-to-back items see no bubble.
  task automatic offer(input logic [1:0] req, input logic [7:0] b);
    while ($urandom_range(99) < src_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= req;
    s_tdata  <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
  endtask

  // APB write followed by a read-back; the checker compares the read data.
  task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    if (idx == REG_HUNT_TO) cur_hunt = value;
    if (idx == REG_FIX_LEN) cur_fix_len = value[8:0];
  endtask

  task automatic set_registers(input logic [15:0] hunt, input logic [15:0] frame,
                               input logic [15:0] long_to, input logic [8:0] fix_len);
    write_reg(REG_HUNT_TO, hunt);
    write_reg(REG_FRAME_TO, frame);
    write_reg(REG_LONG_TO, long_to);
    write_reg(REG_FIX_LEN, {7'd0, fix_len});
  endtask

  // Let every expected result drain. The extra cycles cover items with no
  // result still in flight (results land at the edge after the transfer).
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic logic [7:0] byte_except(input logic [7:0] a, input logic [7:0] c);
    logic [7:0] v;
    v = 8'($urandom);
    while (v == a || v == c) v = 8'($urandom);
    return v;
  endfunction

  task automatic stray_tick();
    if ($urandom_range(99) < 6) offer(REQ_TICK, 8'($urandom));
  endtask

  // One start request and a frame that is mostly well formed: hunt noise,
  // then a flagged or fixed frame, now and then cut short or never started.
  task automatic random_frame();
    int          kind;
    int          cut;
    logic [7:0]  len_byte;
    logic [7:0]  v;
    offer(REQ_START, 8'($urandom));
    repeat ($urandom_range(0, 2)) begin
      kind = $urandom_range(99);
      if (kind < 30)      offer(REQ_TICK, 8'($urandom));
      else if (kind < 38) offer(REQ_RESERVED, 8'($urandom));
      else                offer(REQ_BYTE, byte_except(BYTE_FLAG, BYTE_FIXED));
    end
    kind = $urandom_range(99);
    if (kind < 10) begin
      // no start byte: run the hunt out (capped when the timeout is large)
      repeat ((cur_hunt < 16'd60) ? cur_hunt + 1 : 60) offer(REQ_TICK, 8'($urandom));
    end else if (kind < 70) begin
      offer(REQ_BYTE, BYTE_FLAG);
      repeat ($urandom_range(0, 2)) offer(REQ_BYTE, byte_except(BYTE_FMT, BYTE_FMT));
      stray_tick();
      offer(REQ_BYTE, BYTE_FMT);
      if ($urandom_range(99) < 20) offer(REQ_BYTE, 8'($urandom_range(0, 1)));
      kind = $urandom_range(99);
      // lengths that give the known frame types (count = length + 2)
      if (kind < 5)       len_byte = 8'd121;
      else if (kind < 10) len_byte = 8'd119;
      else if (kind < 15) len_byte = 8'd112;
      else if (kind < 17) len_byte = 8'($urandom_range(128, 255));
      else                len_byte = 8'($urandom_range(2, 20));
      offer(REQ_BYTE, len_byte);
      cut = len_byte - 1;
      if ($urandom_range(99) < 10) cut = $urandom_range(0, cut);
      for (int i = 0; i < cut; i++) begin
        stray_tick();
        v = 8'($urandom);
        if (i == len_byte - 2 && $urandom_range(99) < 70) v = BYTE_FLAG;
        offer(REQ_BYTE, v);
      end
    end else if (kind < 92) begin
      offer(REQ_BYTE, BYTE_FIXED);
      cut = cur_fix_len - 1;
      if ($urandom_range(99) < 10) cut = $urandom_range(0, cut);
      for (int i = 0; i < cut; i++) begin
        stray_tick();
        offer(REQ_BYTE, 8'($urandom));
      end
    end
    // otherwise the frame is left open and the next start drops it
    if ($urandom_range(99) < 10) begin
      offer(REQ_BYTE, 8'($urandom));
      offer(REQ_TICK, 8'($urandom));
    end
  endtask

  initial begin : stimulus
    int first;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // ---- directed part ----
    set_registers(16'd5, 16'd6, 16'd7, 9'd1);
    offer(REQ_TICK, 8'h00);       // idle: tick, byte and reserved code ignored
    offer(REQ_BYTE, 8'hFF);
    offer(REQ_RESERVED, 8'h7E);
    offer(REQ_START, 8'h00);
    offer(REQ_TICK, 8'h00);
    offer(REQ_BYTE, 8'h00);       // hunt noise
    offer(REQ_BYTE, BYTE_FLAG);
    offer(REQ_BYTE, 8'hFF);       // skipped before the format byte
    offer(REQ_BYTE, BYTE_FMT);
    offer(REQ_BYTE, 8'h00);       // lengths below two: echoed, count 3, still waiting
    offer(REQ_BYTE, 8'h01);
    offer(REQ_BYTE, 8'h04);       // six-byte frame
    offer(REQ_BYTE, 8'h11);
    offer(REQ_BYTE, 8'h22);
    offer(REQ_BYTE, BYTE_FLAG);   // closing flag sets end_byte_ok
    offer(REQ_START, 8'hFF);
    offer(REQ_BYTE, BYTE_FIXED);  // fixed length of one: echo and summary together
    offer(REQ_START, 8'h00);
    offer(REQ_BYTE, BYTE_FLAG);
    offer(REQ_RESERVED, 8'hFF);
    offer(REQ_START, 8'h00);      // restart while busy drops the open frame
    repeat (5) offer(REQ_TICK, 8'hFF);  // hunt timeout with count 0
    drain();

    // longer hunt timeout: closes exactly on its last tick
    write_reg(REG_HUNT_TO, 16'd50);
    offer(REQ_START, 8'h00);
    repeat (50) offer(REQ_TICK, 8'($urandom));
    drain();

    // ---- random part: flow-control mix changes every two settings ----
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: set_registers(16'hFFFF, 16'hFFFF, 16'hFFFF, 9'd511);
        1: set_registers(16'd0, 16'd0, 16'd0, 9'd1);
        3: set_registers(16'($urandom_range(1, 20)), 16'd0, 16'd0,
                         9'($urandom_range(11, 40)));
        6: set_registers(16'($urandom_range(1, 20)), 16'($urandom_range(2, 40)), 16'hFFFF,
                         9'($urandom_range(11, 120)));
        default: set_registers(16'($urandom_range(1, 20)), 16'($urandom_range(2, 40)),
                               16'($urandom_range(2, 60)), 9'($urandom_range(2, 40)));
      endcase
      case (p / 2)
        0: begin src_idle = 0;  sink_stall <= 0;  end
        1: begin src_idle = 59; sink_stall <= 0;  end
        2: begin src_idle = 0;  sink_stall <= 59; end
        default: begin src_idle = 16; sink_stall <= 16; end
      endcase
      // long sink hold-off while the source keeps going
      if (p == 4 || p == 5) hold_requests <= hold_requests + 1;
      first = items_sent;
      while (items_sent - first < PhaseItems) random_frame();
      drain();
    end

    src_idle = 0;
    run_done <= 1'b1;
    repeat (2) @(posedge clk);
    if (mismatches == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
